FILE: src/lzwe_pkg.sv
`default_nettype none
package lzwe_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
  localparam int NFC_W         = MAX_CODE_BITS + 2;
  localparam int ENTRY_W       = MAX_CODE_BITS + 8;

  localparam logic [1:0] REG_MIN_CODE_SIZE = 2'd0;
  localparam logic [1:0] REG_MAX_CODE_SIZE = 2'd1;
  localparam logic [1:0] REG_EARLY_CHANGE  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } lzwe_in_t;

  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] code;
    logic [3:0]               code_width;
    logic                     last_code;
  } lzwe_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_M,
    ST_COUNT,
    ST_EMIT_CLR,
    ST_LASTCHK,
    ST_EMIT_FM,
    ST_EMIT_END
  } lzwe_state_t;

endpackage
`default_nettype wire

FILE: src/lzwe_ram.sv
`default_nettype none
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/lzw_variable_width_encoder.sv
`default_nettype none
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | lzwe_in_t  (data_byte, last_byte)
// out     | output    | out_valid/stall | lzwe_out_t (code, code_width, last_code)
// cfg     | input     | cfg_we          | cfg_index, cfg_wdata
// A byte that extends the match is looked up by a linear search of the dictionary, one
// entry read and then compared at a time; a miss emits the match code, a full table a
// clear code and the last byte of a stream the final match and the end code.
// Reset is synchronous; the dictionary needs no clearing pass.
// The input stalls in the cycle after a register write while the sizes settle.
// A stall on the output holds the sequencer at its next code emission.
module lzw_variable_width_encoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lzwe_pkg::lzwe_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lzwe_pkg::lzwe_out_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_wdata
);
  import lzwe_pkg::*;

  lzwe_state_t state_r, state_nxt;

  logic [3:0] min_r, min_nxt;
  logic [3:0] max_r, max_nxt;
  logic       ec_r, ec_nxt;

  logic [NFC_W-1:0]         nfc_r, nfc_nxt;
  logic [3:0]               wnow_r, wnow_nxt;
  logic [MAX_CODE_BITS-1:0] cm_r, cm_nxt;
  logic                     mv_r, mv_nxt;
  logic                     started_r, started_nxt;
  logic [7:0]               b_r, b_nxt;
  logic                     last_r, last_nxt;
  logic                     final_r, final_nxt;
  logic [NFC_W-1:0]         k_r, k_nxt;
  logic [NFC_W-1:0]         top_r, top_nxt;

  logic       out_valid_r, out_valid_nxt;
  lzwe_out_t  out_data_r, out_data_nxt;

  logic [3:0]               eff_min, eff_max;
  logic [NFC_W-1:0]         clear_code, cap, thr, nfc_inc;
  logic [7:0]               bmask;
  logic                     can_emit;
  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [MAX_CODE_BITS-1:0] ram_waddr;

  logic cfg_hit_r;
  logic [3:0] wstart;

  // Clamped sizes and derived codes.
  always_comb begin
    eff_min = min_r;
    if (eff_min < 4'd2) eff_min = 4'd2;
    if (eff_min > 4'd8) eff_min = 4'd8;
    eff_max = max_r;
    if (eff_max > 4'(MAX_CODE_BITS)) eff_max = 4'(MAX_CODE_BITS);
    if (eff_max < eff_min + 4'd1) eff_max = eff_min + 4'd1;
  end

  assign clear_code = NFC_W'(1) << eff_min;
  assign cap        = NFC_W'(1) << eff_max;
  assign bmask      = 8'hFF >> (4'd8 - eff_min);
  assign nfc_inc    = nfc_r + NFC_W'(1);
  assign thr        = (NFC_W'(1) << wnow_r) + NFC_W'(1) - NFC_W'(ec_r);
  assign can_emit   = !out_valid_r || !out_stall;
  assign ram_waddr  = cm_r;

  lzwe_ram #(.WIDTH(ENTRY_W), .DEPTH(DICT_DEPTH)) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nfc_r[MAX_CODE_BITS-1:0]),
    .wdata ({ram_waddr, b_r}),
    .raddr (k_r[MAX_CODE_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid && !cfg_hit_r) state_nxt = ST_START;
      ST_START:    if (started_r || can_emit) state_nxt = ST_MATCH;
      ST_MATCH:    state_nxt = mv_r ? ST_SCAN_RD : ST_LASTCHK;
      ST_SCAN_RD:  state_nxt = (k_r < top_r) ? ST_SCAN_CMP : ST_EMIT_M;
      ST_SCAN_CMP: begin
        if (ram_rdata == {cm_r, b_r}) state_nxt = ST_LASTCHK;
        else state_nxt = ST_SCAN_RD;
      end
      ST_EMIT_M:   if (can_emit) state_nxt = ST_COUNT;
      ST_COUNT: begin
        if (nfc_inc >= thr && wnow_r >= eff_max && !final_r) state_nxt = ST_EMIT_CLR;
        else if (final_r) state_nxt = ST_EMIT_END;
        else state_nxt = ST_LASTCHK;
      end
      ST_EMIT_CLR: if (can_emit) state_nxt = ST_LASTCHK;
      ST_LASTCHK:  state_nxt = last_r ? ST_EMIT_FM : ST_IDLE;
      ST_EMIT_FM:  if (can_emit) state_nxt = ST_COUNT;
      ST_EMIT_END: if (can_emit) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    min_nxt       = min_r;
    max_nxt       = max_r;
    ec_nxt        = ec_r;
    nfc_nxt       = nfc_r;
    wnow_nxt      = wnow_r;
    cm_nxt        = cm_r;
    mv_nxt        = mv_r;
    started_nxt   = started_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    final_nxt     = final_r;
    k_nxt         = k_r;
    top_nxt       = top_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_hit_r) begin
          b_nxt     = in_data.data_byte & bmask;
          last_nxt  = in_data.last_byte;
          final_nxt = 1'b0;
        end
      end
      ST_START: begin
        if (!started_r && can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{code: clear_code[MAX_CODE_BITS-1:0],
                            code_width: wnow_r, last_code: 1'b0};
          started_nxt   = 1'b1;
        end
      end
      ST_MATCH: begin
        if (!mv_r) begin
          cm_nxt = MAX_CODE_BITS'(b_r);
          mv_nxt = 1'b1;
        end
        k_nxt   = clear_code + NFC_W'(2);
        top_nxt = (nfc_r < cap) ? nfc_r : cap;
      end
      ST_SCAN_CMP: begin
        if (ram_rdata == {cm_r, b_r}) cm_nxt = k_r[MAX_CODE_BITS-1:0];
        else k_nxt = k_r + NFC_W'(1);
      end
      ST_EMIT_M: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{code: cm_r, code_width: wnow_r, last_code: 1'b0};
          ram_we        = nfc_r < cap;
          cm_nxt        = MAX_CODE_BITS'(b_r);
        end
      end
      ST_COUNT: begin
        nfc_nxt = nfc_inc;
        if (nfc_inc >= thr && wnow_r < eff_max) wnow_nxt = wnow_r + 4'd1;
      end
      ST_EMIT_CLR: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{code: clear_code[MAX_CODE_BITS-1:0],
                            code_width: wnow_r, last_code: 1'b0};
          nfc_nxt       = clear_code + NFC_W'(2);
          wnow_nxt      = eff_min + 4'd1;
        end
      end
      ST_EMIT_FM: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{code: cm_r, code_width: wnow_r, last_code: 1'b0};
          final_nxt     = 1'b1;
        end
      end
      ST_EMIT_END: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{code: clear_code[MAX_CODE_BITS-1:0] + MAX_CODE_BITS'(1),
                            code_width: wnow_r, last_code: 1'b1};
          nfc_nxt       = clear_code + NFC_W'(2);
          wnow_nxt      = eff_min + 4'd1;
          cm_nxt        = '0;
          mv_nxt        = 1'b0;
          started_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
    // A write to one of the three registers restarts the stream with the new settings.
    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CODE_SIZE: min_nxt = cfg_wdata;
        REG_MAX_CODE_SIZE: max_nxt = cfg_wdata;
        REG_EARLY_CHANGE:  ec_nxt  = cfg_wdata[0];
        default: ;
      endcase
      if (cfg_index <= REG_EARLY_CHANGE) begin
        started_nxt = 1'b0;
        mv_nxt      = 1'b0;
        cm_nxt      = '0;
        nfc_nxt     = '0;
        wnow_nxt    = '0;
      end
    end
  end

  assign wstart = eff_min + 4'd1;

  // State registers; sizes settle in the cycle after a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= 4'd8;
      max_r       <= 4'd12;
      ec_r        <= 1'b0;
      cfg_hit_r   <= 1'b1;
      nfc_r       <= '0;
      wnow_r      <= '0;
      cm_r        <= '0;
      mv_r        <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ec_r        <= ec_nxt;
      cfg_hit_r   <= cfg_we && (cfg_index <= REG_EARLY_CHANGE);
      cm_r        <= cm_nxt;
      mv_r        <= mv_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
      if (cfg_hit_r) begin
        nfc_r  <= clear_code + NFC_W'(2);
        wnow_r <= wstart;
      end else begin
        nfc_r  <= nfc_nxt;
        wnow_r <= wnow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    k_r        <= k_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE) || cfg_hit_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and table state.
  a_wnow_max: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_hit_r |-> wnow_r <= 4'(MAX_CODE_BITS)) else $error("width above maximum");
  a_nfc_max: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r <= NFC_W'(DICT_DEPTH + 1)) else $error("next free code overflow");
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN_CMP |-> $past(state_r) == ST_SCAN_RD) else $error("compare without read");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_END && can_emit) |=> (out_valid && out_data.last_code))
    else $error("end code not marked last");

endmodule
`default_nettype wire

FILE: sim/lzw_variable_width_encoder_test.sv
`timescale 1ns / 100ps
module lzw_variable_width_encoder_test;
  import lzwe_pkg::*;

  typedef struct {
    lzwe_in_t item;
    bit       pause;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lzwe_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lzwe_out_t out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_wdata;

  lzw_variable_width_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Pending byte transactions and the codes we expect the encoder to emit.
  pending_t  send_q[$];
  lzwe_out_t code_q[$];
  int        mismatches = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        quiet = 0;
  logic      in_taken = 0;
  int        cycles = 0;

  // Encoder shadow state.
  logic [3:0]  min_reg;
  logic [3:0]  max_reg;
  logic        early_reg;
  logic [11:0] dict_pfx [DICT_DEPTH];
  logic [7:0]  dict_sfx [DICT_DEPTH];
  int          free_code;
  int          width_cur;
  int          match_code;
  bit          match_ok;
  bit          stream_open;

  always #10 clk = ~clk;

  function automatic int root_bits();
    int m;
    m = min_reg;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic int top_bits();
    int m;
    m = max_reg;
    if (m > MAX_CODE_BITS) m = MAX_CODE_BITS;
    if (m < root_bits() + 1) m = root_bits() + 1;
    return m;
  endfunction

  function automatic void restart_table();
    free_code = (1 << root_bits()) + 2;
    width_cur = root_bits() + 1;
  endfunction

  function automatic void restart_stream();
    restart_table();
    match_code  = 0;
    match_ok    = 0;
    stream_open = 0;
  endfunction

  function automatic void push_code(int code, bit fin);
    lzwe_out_t r;
    r.code       = code[11:0];
    r.code_width = width_cur[3:0];
    r.last_code  = fin;
    code_q.push_back(r);
  endfunction

  // Advance the free code; widen, or clear the table at the widest code when may_clear is set.
  function automatic void advance_slot(bit may_clear);
    int thr;
    free_code++;
    thr = (1 << width_cur) + 1 - early_reg;
    if (free_code >= thr) begin
      if (width_cur < top_bits()) begin
        width_cur++;
      end else if (may_clear) begin
        push_code(1 << root_bits(), 0);
        restart_table();
      end
    end
  endfunction

  // Work out the codes that one accepted byte produces.
  function automatic void encode_byte(lzwe_in_t t);
    int  clr;
    int  b;
    int  cap;
    int  lim;
    int  k;
    bit  hit;
    clr = 1 << root_bits();
    b   = t.data_byte & (clr - 1);
    cap = 1 << top_bits();
    if (!stream_open) begin
      push_code(clr, 0);
      stream_open = 1;
    end
    if (!match_ok) begin
      match_code = b;
      match_ok   = 1;
    end else begin
      lim = (free_code < cap) ? free_code : cap;
      hit = 0;
      for (k = clr + 2; k < lim; k++) begin
        if (dict_pfx[k] == match_code && dict_sfx[k] == b) begin
          hit = 1;
          break;
        end
      end
      if (hit) begin
        match_code = k;
      end else begin
        push_code(match_code, 0);
        if (free_code < cap) begin
          dict_pfx[free_code] = match_code[11:0];
          dict_sfx[free_code] = b[7:0];
        end
        advance_slot(1);
        match_code = b;
      end
    end
    if (t.last_byte) begin
      push_code(match_code, 0);
      advance_slot(0);
      push_code(clr + 1, 1);
      restart_stream();
    end
  endfunction

  // Monitor: track accepted transactions and check emitted codes.
  always @(posedge clk) begin
    lzwe_out_t want;
    cycles <= cycles + 1;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_CODE_SIZE: min_reg = cfg_wdata;
          REG_MAX_CODE_SIZE: max_reg = cfg_wdata;
          REG_EARLY_CHANGE:  early_reg = cfg_wdata[0];
          default: ;
        endcase
        restart_stream();
      end
      if (in_valid && !in_stall) encode_byte(in_data);
      if (out_valid && !out_stall) begin
        if (code_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected code %0d width %0d last %0d", out_data.code,
                     out_data.code_width, out_data.last_code);
        end else begin
          want = code_q.pop_front();
          if (want.code != out_data.code || want.code_width != out_data.code_width ||
              want.last_code != out_data.last_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("code mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.code, want.code_width, want.last_code, out_data.code,
                       out_data.code_width, out_data.last_code);
          end
        end
      end
    end
  end

  // Driver: present bytes from the pending queue with random idle bursts.
  always @(negedge clk) begin
    logic nv;
    pending_t p;
    if (rst_n && !(in_valid && !in_taken)) begin
      nv = 0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (send_q.size() > 0) begin
        if (send_q[0].pause) begin
          if (code_q.size() == 0) void'(send_q.pop_front());
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 11);
        end else begin
          p = send_q.pop_front();
          in_data <= p.item;
          nv = 1;
        end
      end
      in_valid <= nv;
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1;
    end else if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 11) - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("[lzw_variable_width_encoder] ERROR");
      $finish;
    end
  end

  task automatic queue_byte(int b, bit fin);
    pending_t p;
    p.item.data_byte = b[7:0];
    p.item.last_byte = fin;
    p.pause = 0;
    send_q.push_back(p);
  endtask

  task automatic queue_pause();
    pending_t p;
    p.item = '0;
    p.pause = 1;
    send_q.push_back(p);
  endtask

  // A stream of random length over a small alphabet so that matches grow.
  task automatic queue_stream(int maxlen, int alpha);
    int len;
    int b;
    len = $urandom_range(1, maxlen);
    for (int i = 0; i < len; i++) begin
      b = $urandom_range(0, alpha - 1);
      if ($urandom_range(0, 4) == 0) b = $urandom_range(0, 255);
      queue_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (send_q.size() != 0 || (in_valid && !in_taken) || code_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Settings per phase: minimum code size, maximum code size, early change, longest stream.
  int ph_min[8]   = '{8, 2, 2, 3, 4, 15, 0, 8};
  int ph_max[8]   = '{12, 3, 3, 5, 12, 15, 0, 9};
  int ph_early[8] = '{0, 0, 1, 1, 0, 1, 0, 1};
  int ph_len[8]   = '{30, 60, 60, 80, 50, 30, 60, 40};

  initial begin
    int budget;
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = REG_MIN_CODE_SIZE;
    cfg_wdata = 0;
    min_reg = 8;
    max_reg = 12;
    early_reg = 0;
    restart_stream();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: single byte streams at both extremes, a run, alternation.
    queue_byte(8'h00, 1);
    queue_byte(8'hFF, 1);
    for (int i = 0; i < 5; i++) queue_byte(8'hFF, 0);
    queue_byte(8'h80, 1);
    queue_pause();
    for (int i = 0; i < 10; i++) queue_byte(i[0] ? 8'h62 : 8'h61, i == 9);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(REG_MIN_CODE_SIZE, 4'(ph_min[ph]));
        write_reg(REG_MAX_CODE_SIZE, 4'(ph_max[ph]));
        write_reg(REG_EARLY_CHANGE, 4'(ph_early[ph]));
      end
      if (ph == 7) quiet = 1;
      budget = 35;
      while (budget > 0) begin
        int before_n;
        before_n = send_q.size();
        queue_stream(ph_len[ph], (ph % 2 == 0) ? 3 : 4);
        budget -= send_q.size() - before_n;
        if ($urandom_range(0, 5) == 0) queue_pause();
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[lzw_variable_width_encoder] OK");
    end else begin
      $display("[lzw_variable_width_encoder] ERROR");
    end
    $finish;
  end

endmodule
